@@ sv/srb_pkg.sv @@
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the sequence reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int SEQ_W = 8;
  localparam int TAG_W = 16;
  localparam int LEN_W = 10;
  localparam int LIM_W = 6;
  localparam int CNT_W = 6;
  localparam int STS_W = 2;

  localparam int WINDOW_SLOTS_DEF = 32;
  localparam int MAX_DRAIN = 32;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(31);

  localparam int IN_FIELDS_W  = SEQ_W + TAG_W + LEN_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SEQ_W + TAG_W + LEN_W + STS_W + CNT_W + SEQ_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [STS_W-1:0] {
    ST_ACCEPT  = 2'd0,
    ST_DUP     = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Classified arrival handed from the front to the drain engine.
  typedef struct packed {
    status_t status;
  } srb_cmd_t;

  // Slot write / lookup request from the front.
  typedef struct packed {
    logic             en;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } srb_wr_t;

  // Slot read-and-free request from the drain engine.
  typedef struct packed {
    logic             en;
    logic [SEQ_W-1:0] seq;
  } srb_rd_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } srb_ent_t;

endpackage

@@ sv/srb_slots.sv @@
// ----------------------------------------------------------------------------
// srb_slots
// Slot store: per-slot valid flags plus tag/length memory.
// ----------------------------------------------------------------------------
module srb_slots
  import srb_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  srb_wr_t          wr,
  output logic             chk_valid,
  input  srb_rd_t          rd,
  output logic             rd_valid,
  output logic [TAG_W-1:0] rd_tag,
  output logic [LEN_W-1:0] rd_len
);

  localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int SEQ_N = 2 ** SEQ_W;

  logic [IDX_W-1:0] slot_lut [SEQ_N];
  logic [WINDOW_SLOTS-1:0] valid_r;
  srb_ent_t mem [WINDOW_SLOTS];
  srb_ent_t rd_data_r;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  // Sequence number to slot, folded at elaboration.
  always_comb begin
    for (int i = 0; i < SEQ_N; i++) begin
      slot_lut[i] = IDX_W'(i % WINDOW_SLOTS);
    end
  end

  assign wr_idx    = slot_lut[wr.seq];
  assign rd_idx    = slot_lut[rd.seq];
  assign chk_valid = valid_r[wr_idx];
  assign rd_valid  = valid_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rd.en) begin
        valid_r[rd_idx] <= 1'b0;
      end
      if (wr.en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= '{tag: wr.tag, len: wr.len};
    end
    if (rd.en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_tag = rd_data_r.tag;
  assign rd_len = rd_data_r.len;

endmodule

@@ sv/srb_front.sv @@
// ----------------------------------------------------------------------------
// srb_front
// Arrival stage: take a packet, check window and duplicate, store it.
// ----------------------------------------------------------------------------
module srb_front
  import srb_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  accept_ok,
  input  logic [LIM_W-1:0]      limit,
  input  logic [SEQ_W-1:0]      expected_seq,
  input  logic                  chk_valid,
  output srb_wr_t               wr,
  output logic                  cmd_push,
  output srb_cmd_t              cmd
);

  localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(WINDOW_SLOTS - 1);

  logic             held_r, held_nxt;
  logic [SEQ_W-1:0] seq_r;
  logic [TAG_W-1:0] tag_r;
  logic [LEN_W-1:0] len_r;
  logic [LIM_W-1:0] lim_eff;
  logic [SEQ_W-1:0] ahead;
  logic             take;
  status_t          status;

  assign in_tready = !held_r && accept_ok;
  assign take      = in_tvalid && in_tready;

  // Saturate the window so an accepted packet never aliases the head slot.
  assign lim_eff = (limit > LIM_MAX) ? LIM_MAX : limit;
  assign ahead   = seq_r - expected_seq;

  always_comb begin
    priority if (ahead > SEQ_W'(lim_eff)) begin
      status = ST_OUTSIDE;
    end else if (chk_valid) begin
      status = ST_DUP;
    end else begin
      status = ST_ACCEPT;
    end
  end

  assign wr.en      = held_r && (status == ST_ACCEPT);
  assign wr.seq     = seq_r;
  assign wr.tag     = tag_r;
  assign wr.len     = len_r;
  assign cmd_push   = held_r;
  assign cmd.status = status;

  always_comb begin
    held_nxt = held_r;
    if (take) begin
      held_nxt = 1'b1;
    end else if (held_r) begin
      held_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seq_r <= in_tdata[SEQ_W-1:0];
      tag_r <= in_tdata[SEQ_W +: TAG_W];
      len_r <= in_tdata[SEQ_W+TAG_W +: LEN_W];
    end
  end

endmodule

@@ sv/srb_cmdq.sv @@
// ----------------------------------------------------------------------------
// srb_cmdq
// Two-entry queue of classified arrivals between front and drain engine.
// ----------------------------------------------------------------------------
module srb_cmdq
  import srb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  srb_cmd_t push_cmd,
  input  logic     pop,
  output logic     q_valid,
  output srb_cmd_t q_cmd
);

  srb_cmd_t   ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rd_ptr_r];
  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/srb_back.sv @@
// ----------------------------------------------------------------------------
// srb_back
// Drain engine: release in-order packets, then the status result.
// ----------------------------------------------------------------------------
module srb_back
  import srb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  srb_cmd_t               q_cmd,
  output logic                   q_pop,
  output srb_rd_t                rd,
  input  logic                   rd_valid,
  input  logic [TAG_W-1:0]       rd_tag,
  input  logic [LEN_W-1:0]       rd_len,
  output logic [SEQ_W-1:0]       expected_seq,
  output logic                   busy,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_CHECK  = 4'b0010,
    B_DATA   = 4'b0100,
    B_STATUS = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [SEQ_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  status_t          sts_r, sts_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_free;
  logic                   load;

  assign out_free     = !out_valid_r || out_tready;
  assign expected_seq = exp_r;
  assign busy         = (state_r != B_IDLE);
  assign rd.seq       = exp_r;

  always_comb begin
    state_nxt    = state_r;
    exp_nxt      = exp_r;
    cnt_nxt      = cnt_r;
    sts_nxt      = sts_r;
    q_pop        = 1'b0;
    rd.en        = 1'b0;
    load         = 1'b0;
    out_data_nxt = out_data_r;
    out_kind_nxt = out_kind_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          sts_nxt   = q_cmd.status;
          cnt_nxt   = '0;
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        // Free the head slot and fetch it, or stop the run.
        if (rd_valid && (cnt_r != CNT_W'(MAX_DRAIN))) begin
          rd.en     = 1'b1;
          state_nxt = B_DATA;
        end else begin
          state_nxt = B_STATUS;
        end
      end
      B_DATA: begin
        if (out_free) begin
          load         = 1'b1;
          out_kind_nxt = KIND_RELEASE;
          out_last_nxt = 1'b0;
          out_data_nxt = {{PAD_W{1'b0}}, {SEQ_W{1'b0}}, {CNT_W{1'b0}}, ST_ACCEPT,
                          rd_len, rd_tag, exp_r};
          exp_nxt      = exp_r + 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          state_nxt    = B_CHECK;
        end
      end
      B_STATUS: begin
        if (out_free) begin
          load         = 1'b1;
          out_kind_nxt = KIND_STATUS;
          out_last_nxt = 1'b1;
          out_data_nxt = {{PAD_W{1'b0}}, exp_r, cnt_r, sts_r,
                          {LEN_W{1'b0}}, {TAG_W{1'b0}}, {SEQ_W{1'b0}}};
          state_nxt    = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      exp_r       <= '0;
      cnt_r       <= '0;
      sts_r       <= ST_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      cnt_r       <= cnt_nxt;
      sts_r       <= sts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

@@ sv/seq_reorder_buffer.sv @@
// ----------------------------------------------------------------------------
// seq_reorder_buffer
// Receive-side reorder buffer for 8-bit sequence numbers (selective repeat).
// The front registers an arrival and pushes its status into the command
//   queue; the drain engine pops it and reads one slot per pass through
//   CHECK and DATA, one pass per release, then sends STATUS. A new arrival
//   is taken only once the drain engine is done with the previous one.
// Reset: synchronous, active low; clears all slot valid flags and the
//   expected sequence number, and sets the window limit to 31.
// ----------------------------------------------------------------------------
module seq_reorder_buffer
  import srb_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input packets.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] seq_num, [23:8] payload_tag, [33:24] payload_len, rest zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Results.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] out_seq, [23:8] out_tag, [33:24] out_len, [35:34] status,
  // [41:36] released_count, [49:42] next_expected, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] kind
  output logic                   out_tuser,
  output logic                   out_tlast,
  // Window limit register.
  input  logic                   cfg_wr_en,
  input  logic [LIM_W-1:0]       cfg_wr_data
);

  logic [LIM_W-1:0] limit_r, limit_nxt;

  srb_wr_t          wr;
  srb_rd_t          rd;
  srb_cmd_t         push_cmd;
  srb_cmd_t         q_cmd;
  logic             cmd_push;
  logic             q_valid;
  logic             q_pop;
  logic             chk_valid;
  logic             rd_valid;
  logic [TAG_W-1:0] rd_tag;
  logic [LEN_W-1:0] rd_len;
  logic [SEQ_W-1:0] expected_seq;
  logic             back_busy;
  logic             accept_ok;

  // Hold the window limit; the user writes it only while idle, unenforced.
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_wr_en) begin
      limit_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // The next arrival is classified against the expected number that the
  // previous one leaves behind, so admit it only once the drain is done.
  assign accept_ok = !q_valid && !back_busy;

  srb_front #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .accept_ok    (accept_ok),
    .limit        (limit_r),
    .expected_seq (expected_seq),
    .chk_valid    (chk_valid),
    .wr           (wr),
    .cmd_push     (cmd_push),
    .cmd          (push_cmd)
  );

  srb_slots #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .chk_valid (chk_valid),
    .rd        (rd),
    .rd_valid  (rd_valid),
    .rd_tag    (rd_tag),
    .rd_len    (rd_len)
  );

  // Decouple classification from the drain engine.
  srb_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Walk the expected slot forward, one release per output transfer,
  // and close every arrival with its status transfer.
  srb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .rd           (rd),
    .rd_valid     (rd_valid),
    .rd_tag       (rd_tag),
    .rd_len       (rd_len),
    .expected_seq (expected_seq),
    .busy         (back_busy),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast)
  );

endmodule
